FILE: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, sizes and element conversions for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY     = 64;
    localparam int ELEMENT_BITS = 32;

    localparam int LEN_BITS = $clog2(CAPACITY + 1);
    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_BITS = 7;
    localparam int CMP_BITS = ((LEN_BITS > POS_BITS) ? LEN_BITS : POS_BITS) + 1;

    typedef logic [ELEMENT_BITS-1:0] elem_t;

    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_LOCATE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Per-cell control, decoded once per accepted word
    typedef struct packed {
        logic capture;   // a word is accepted this cycle
        logic shift_up;  // take the left neighbor
        logic shift_dn;  // take the right neighbor
        logic load;      // take the incoming value
        logic hit;       // this cell is read by get or delete
        logic seek;      // this cell takes part in locate
    } cell_ctrl_t;

    function automatic elem_t to_elem(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[ELEMENT_BITS-1:0];
    endfunction

    function automatic logic [31:0] from_elem(input elem_t e);
        logic signed [63:0] w;
        w = 64'(signed'(e));
        return w[31:0];
    endfunction

endpackage

FILE: rtl/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: shifts with its neighbors, loads, and flags reads/matches.
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic               aclk,
    input  pal_pkg::cell_ctrl_t ctrl,
    input  pal_pkg::elem_t     left_elem,
    input  pal_pkg::elem_t     right_elem,
    input  pal_pkg::elem_t     in_elem,
    output pal_pkg::elem_t     entry,
    output pal_pkg::elem_t     pick,
    output logic               match
);

    pal_pkg::elem_t entry_reg, entry_next;
    pal_pkg::elem_t pick_reg, pick_next;
    logic           match_reg, match_next;

    always_comb begin
        entry_next = entry_reg;
        pick_next  = pick_reg;
        match_next = match_reg;
        if (ctrl.capture) begin
            unique if (ctrl.load) begin
                entry_next = in_elem;
            end else if (ctrl.shift_up) begin
                entry_next = left_elem;
            end else if (ctrl.shift_dn) begin
                entry_next = right_elem;
            end else begin
                entry_next = entry_reg;
            end
            // capture the word before any shift moves it
            pick_next  = ctrl.hit ? entry_reg : '0;
            match_next = ctrl.seek && (entry_reg == in_elem);
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        pick_reg  <= pick_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign pick  = pick_reg;
    assign match = match_reg;

endmodule

FILE: rtl/pal_reduce.sv
// ----------------------------------------------------------------------------
// pal_reduce
// Merges the cells' captured read words and finds the first matching cell.
// ----------------------------------------------------------------------------
module pal_reduce (
    input  pal_pkg::elem_t                     pick [pal_pkg::CAPACITY],
    input  logic [pal_pkg::CAPACITY-1:0]       match,
    output pal_pkg::elem_t                     word,
    output logic                               any_match,
    output logic [pal_pkg::IDX_BITS-1:0]       first_idx
);

    always_comb begin
        word = '0;
        for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
            word = word | pick[i];
        end
    end

    always_comb begin
        first_idx = '0;
        for (int i = pal_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                first_idx = pal_pkg::IDX_BITS'(i);
            end
        end
    end

    assign any_match = |match;

endmodule

FILE: rtl/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed words kept in a row of entry cells.
// ----------------------------------------------------------------------------
// Cells and pending registers capture a request, then the result register.
// Throughput: one request per cycle unless the result stalls; all cells
// shift and compare in parallel. A stalled result holds the request in the
// cells' capture stage. Reset (aresetn low, synchronous) empties the list
// and drops pending words; entry contents are not cleared.
module positional_array_list_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [6:0]  s_position,
    input  logic [31:0] s_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_data_out,
    output logic [6:0]  m_found_position,
    output logic [6:0]  m_count
);

    localparam int CAP = pal_pkg::CAPACITY;
    localparam int CB  = pal_pkg::CMP_BITS;

    // control state
    logic [pal_pkg::LEN_BITS-1:0] len_reg, len_next;
    logic                         busy_reg, busy_next;
    logic                         m_valid_reg, m_valid_next;

    // captured request summary
    pal_pkg::status_t pend_status_reg, pend_status_next;
    logic             pend_locate_reg, pend_locate_next;
    logic [6:0]       pend_count_reg, pend_count_next;

    // result register
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_data_reg, m_data_next;
    logic [6:0]  m_found_reg, m_found_next;
    logic [6:0]  m_count_reg, m_count_next;

    logic accept, out_load;
    logic ins_ok, del_ok, get_ok, seek_on;
    logic [CB-1:0] pos_w, len_w;
    pal_pkg::elem_t in_elem;

    pal_pkg::elem_t entry [CAP];
    pal_pkg::elem_t pick  [CAP];
    logic [CAP-1:0] match;

    pal_pkg::elem_t               red_word;
    logic                         red_any;
    logic [pal_pkg::IDX_BITS-1:0] red_idx;

    assign out_load = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !busy_reg || out_load;
    assign accept   = s_valid && s_ready;

    assign pos_w   = CB'(s_position);
    assign len_w   = CB'(len_reg);
    assign in_elem = pal_pkg::to_elem(s_value);

    // request decode against the pre-operation length
    always_comb begin
        ins_ok           = 1'b0;
        del_ok           = 1'b0;
        get_ok           = 1'b0;
        seek_on          = 1'b0;
        len_next         = len_reg;
        pend_status_next = pend_status_reg;
        pend_locate_next = pend_locate_reg;
        pend_count_next  = pend_count_reg;
        if (accept) begin
            pend_status_next = pal_pkg::STAT_OK;
            pend_locate_next = 1'b0;
            unique case (pal_pkg::mode_t'(s_mode))
                pal_pkg::MODE_CLEAR: begin
                    len_next = '0;
                end
                pal_pkg::MODE_INSERT: begin
                    if (len_w >= CB'(CAP)) begin
                        pend_status_next = pal_pkg::STAT_FULL;
                    end else if (pos_w == '0 || pos_w > len_w + CB'(1)) begin
                        pend_status_next = pal_pkg::STAT_RANGE;
                    end else begin
                        ins_ok   = 1'b1;
                        len_next = len_reg + pal_pkg::LEN_BITS'(1);
                    end
                end
                pal_pkg::MODE_DELETE: begin
                    if (pos_w == '0 || pos_w > len_w) begin
                        pend_status_next = pal_pkg::STAT_RANGE;
                    end else begin
                        del_ok   = 1'b1;
                        len_next = len_reg - pal_pkg::LEN_BITS'(1);
                    end
                end
                pal_pkg::MODE_GET: begin
                    if (pos_w == '0 || pos_w > len_w) begin
                        pend_status_next = pal_pkg::STAT_RANGE;
                    end else begin
                        get_ok = 1'b1;
                    end
                end
                pal_pkg::MODE_LOCATE: begin
                    seek_on          = 1'b1;
                    pend_locate_next = 1'b1;
                end
                default: begin
                    pend_status_next = pal_pkg::STAT_RANGE;
                end
            endcase
            pend_count_next = 7'(len_next);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAP; i++) begin : g_cell
            pal_pkg::cell_ctrl_t ctrl;
            pal_pkg::elem_t      left_elem, right_elem;
            logic [CB-1:0]       num;   // 1-based position of this cell

            assign num = CB'(i + 1);

            always_comb begin
                ctrl.capture  = accept;
                ctrl.load     = ins_ok && (num == pos_w);
                ctrl.shift_up = ins_ok && (num > pos_w);
                ctrl.shift_dn = del_ok && (num >= pos_w);
                ctrl.hit      = (get_ok || del_ok) && (num == pos_w);
                ctrl.seek     = seek_on && (num <= len_w);
            end

            if (i == 0) begin : g_first
                assign left_elem = in_elem;
            end else begin : g_mid
                assign left_elem = entry[i-1];
            end
            if (i == CAP - 1) begin : g_last
                assign right_elem = '0;
            end else begin : g_inner
                assign right_elem = entry[i+1];
            end

            pal_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .left_elem  (left_elem),
                .right_elem (right_elem),
                .in_elem    (in_elem),
                .entry      (entry[i]),
                .pick       (pick[i]),
                .match      (match[i])
            );
        end
    endgenerate

    pal_reduce u_reduce (
        .pick      (pick),
        .match     (match),
        .word      (red_word),
        .any_match (red_any),
        .first_idx (red_idx)
    );

    always_comb begin
        busy_next     = busy_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_found_next  = m_found_reg;
        m_count_next  = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_count_next = pend_count_reg;
            m_data_next  = pal_pkg::from_elem(red_word);
            if (pend_locate_reg) begin
                m_status_next = red_any ? pal_pkg::STAT_OK : pal_pkg::STAT_NOT_FOUND;
                m_found_next  = red_any ? (7'(red_idx) + 7'd1) : 7'd0;
            end else begin
                m_status_next = pend_status_reg;
                m_found_next  = 7'd0;
            end
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        pend_status_reg <= pend_status_next;
        pend_locate_reg <= pend_locate_next;
        pend_count_reg  <= pend_count_next;
        m_status_reg    <= m_status_next;
        m_data_reg      <= m_data_next;
        m_found_reg     <= m_found_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_data_out       = m_data_reg;
    assign m_found_position = m_found_reg;
    assign m_count          = m_count_reg;

endmodule
